FILE: hw/rtl/rgl_pkg.sv
package rgl_pkg;

    // Opcodes of an input beat
    localparam logic [1:0] OP_ABNORMAL  = 2'd0;
    localparam logic [1:0] OP_CANDIDATE = 2'd1;
    localparam logic [1:0] OP_FINISH    = 2'd2;

    // Configuration register indexes
    localparam logic REG_INSERTION_POINT = 1'b0;
    localparam logic REG_MIN_QUALITY     = 1'b1;

    // Alignment flag bits
    localparam logic [15:0] FLAG_PAIRED      = 16'h0001;
    localparam logic [15:0] FLAG_PROPER_PAIR = 16'h0002;
    localparam logic [15:0] FLAG_UNMAPPED    = 16'h0004;
    localparam logic [15:0] FLAG_MATE_UNMAP  = 16'h0008;
    localparam logic [15:0] FLAG_DUPLICATE   = 16'h0400;
    localparam logic [15:0] FLAG_SUPPLEMENT  = 16'h0800;

    // Accumulator entry addresses
    localparam logic CLS_ABN  = 1'b0;
    localparam logic CLS_NORM = 1'b1;

    localparam int DEF_PLOIDY    = 2;
    localparam int DEF_COUNT_MAX = 65535;

    localparam int LLH_W     = 38;
    localparam int PHRED_W   = 24;
    localparam int COMP_W    = 16;

    // Sum magnitude ceiling, 2^37
    localparam logic [LLH_W-1:0] SUM_MAX   = 38'h20_0000_0000;
    localparam logic [LLH_W:0]   SUM_MAX_X = 39'h020_0000_0000;

    // round(-65536 * log10(1 - 10^(-q/10))), zero at q = 0 and from q = 48 up
    function automatic logic [COMP_W-1:0] comp_q16(input logic [7:0] q);
        logic [COMP_W-1:0] r;
        begin
            case (q)
                8'd1:    r = 16'd45012;
                8'd2:    r = 16'd28372;
                8'd3:    r = 16'd19796;
                8'd4:    r = 16'd14449;
                8'd5:    r = 16'd10819;
                8'd6:    r = 16'd8233;
                8'd7:    r = 16'd6334;
                8'd8:    r = 16'd4911;
                8'd9:    r = 16'd3830;
                8'd10:   r = 16'd2999;
                8'd11:   r = 16'd2356;
                8'd12:   r = 16'd1855;
                8'd13:   r = 16'd1463;
                8'd14:   r = 16'd1156;
                8'd15:   r = 16'd915;
                8'd16:   r = 16'd724;
                8'd17:   r = 16'd574;
                8'd18:   r = 16'd455;
                8'd19:   r = 16'd361;
                8'd20:   r = 16'd286;
                8'd21:   r = 16'd227;
                8'd22:   r = 16'd180;
                8'd23:   r = 16'd143;
                8'd24:   r = 16'd114;
                8'd25:   r = 16'd90;
                8'd26:   r = 16'd72;
                8'd27:   r = 16'd57;
                8'd28:   r = 16'd45;
                8'd29:   r = 16'd36;
                8'd30:   r = 16'd28;
                8'd31:   r = 16'd23;
                8'd32:   r = 16'd18;
                8'd33:   r = 16'd14;
                8'd34:   r = 16'd11;
                8'd35:   r = 16'd9;
                8'd36:   r = 16'd7;
                8'd37:   r = 16'd6;
                8'd38:   r = 16'd5;
                8'd39:   r = 16'd4;
                8'd40:   r = 16'd3;
                8'd41:   r = 16'd2;
                8'd42:   r = 16'd2;
                8'd43:   r = 16'd1;
                8'd44:   r = 16'd1;
                8'd45:   r = 16'd1;
                8'd46:   r = 16'd1;
                8'd47:   r = 16'd1;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

    // round(65536 * log10(p)), p clamped to 8
    function automatic logic [15:0] log_ploidy_q16(input int p);
        logic [15:0] r;
        begin
            case (p)
                2:       r = 16'd19728;
                3:       r = 16'd31269;
                4:       r = 16'd39457;
                5:       r = 16'd45808;
                6:       r = 16'd50997;
                7:       r = 16'd55384;
                8:       r = 16'd59185;
                default: r = (p > 8) ? 16'd59185 : 16'd0;
            endcase
            return r;
        end
    endfunction

    // (q * 65536 + 5) / 10 = q * 6553 + (6q + 5) / 10; small quotient by reciprocal
    function automatic logic [PHRED_W-1:0] phred_q16(input logic [7:0] q);
        logic [10:0]        y;
        logic [26:0]        prod;
        logic [PHRED_W-1:0] base;
        begin
            y    = 11'(q) * 11'd6 + 11'd5;
            prod = 27'(y) * 27'd52429;
            base = 24'(q) * 24'd6553;
            return base + 24'(prod[26:19]);
        end
    endfunction

    function automatic logic [LLH_W-1:0] sat_add(input logic [LLH_W-1:0] a,
                                                 input logic [LLH_W-1:0] b);
        logic [LLH_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return (s > SUM_MAX_X) ? SUM_MAX : s[LLH_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/read_genotype_likelihood.sv
// Genotype likelihood accumulator: one beat accepted per clock while in_stall is low, any opcode.
// A finish beat is registered through stages 1 and 2, then queued, before out_valid shows its result.
// Results queue in a 4-deep buffer; in_stall rises only when 4 results are queued or pending.
// Accumulators live in a 2-entry synchronous RAM (abnormal, normal) with read-modify-write
// and write forwarding. Reset (rst_n low, async) clears config, entry valid bits and queue.
module read_genotype_likelihood #(
    parameter int PLOIDY    = rgl_pkg::DEF_PLOIDY,
    parameter int COUNT_MAX = rgl_pkg::DEF_COUNT_MAX
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [7:0]         quality,
    input  logic [15:0]        read_flags,
    input  logic [30:0]        read_pos,
    input  logic [30:0]        ref_length,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [37:0] hom_ref_llh,
    output logic               hom_ref_neg_inf,
    output logic signed [37:0] het_llh,
    output logic signed [37:0] hom_alt_llh,
    output logic               hom_alt_neg_inf,
    output logic [15:0]        normal_count,
    output logic [15:0]        abnormal_count,
    output logic               count_overflow
);
    import rgl_pkg::*;

    localparam int CNT_W    = $clog2(COUNT_MAX + 1);
    localparam int TOT_W    = CNT_W + 1;
    localparam int PROD_W   = TOT_W + 16;
    localparam int CX_W     = (CNT_W > 16) ? CNT_W : 16;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    localparam logic [CNT_W-1:0] CMAX       = CNT_W'(COUNT_MAX);
    localparam logic [15:0]      LOG_PLOIDY = log_ploidy_q16(PLOIDY);

    typedef struct packed {
        logic [LLH_W-1:0] phred;
        logic [LLH_W-1:0] comp;
        logic             zero;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    typedef struct packed {
        logic [LLH_W-1:0] ref_llh;
        logic             ref_inf;
        logic [LLH_W-1:0] het;
        logic [LLH_W-1:0] alt_llh;
        logic             alt_inf;
        logic [15:0]      norm_cnt;
        logic [15:0]      abn_cnt;
        logic             ovf;
    } result_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [30:0] insertion_point_reg;
    logic [7:0]  min_quality_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insertion_point_reg <= '0;
            min_quality_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_INSERTION_POINT: insertion_point_reg <= cfg_data;
                REG_MIN_QUALITY:     min_quality_reg     <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: read filter and score terms, launch the RAM read
    // ---------------------------------------------------------------
    logic        in_accept;
    logic        flags_ok;
    logic        span_ok;
    logic [31:0] span_end;
    logic        s0_we;
    logic        s0_fin;
    logic        rd_addr_a;

    assign in_accept = in_valid && !in_stall;

    assign flags_ok = ((read_flags & FLAG_PAIRED) != '0)
                   && ((read_flags & FLAG_PROPER_PAIR) != '0)
                   && ((read_flags & FLAG_UNMAPPED) == '0)
                   && ((read_flags & FLAG_MATE_UNMAP) == '0)
                   && ((read_flags & FLAG_DUPLICATE) == '0)
                   && ((read_flags & FLAG_SUPPLEMENT) == '0);

    // 1-based span [pos+1, pos+max(len,1)]
    assign span_end = {1'b0, read_pos}
                    + ((ref_length == '0) ? 32'd1 : {1'b0, ref_length});
    assign span_ok  = (insertion_point_reg > read_pos)
                   && ({1'b0, insertion_point_reg} <= span_end);

    always_comb
    begin
        s0_we  = 1'b0;
        s0_fin = 1'b0;
        case (opcode)
            OP_ABNORMAL:  s0_we  = 1'b1;
            OP_CANDIDATE: s0_we  = flags_ok && span_ok && (quality >= min_quality_reg);
            OP_FINISH:    s0_fin = 1'b1;
            default:      ;
        endcase
    end

    // port A: class of the beat (abnormal on finish); port B: the other entry
    assign rd_addr_a = (opcode == OP_CANDIDATE) ? CLS_NORM : CLS_ABN;

    logic               s1_we_reg;
    logic               s1_fin_reg;
    logic               s1_cls_reg;
    logic [PHRED_W-1:0] s1_phred_reg;
    logic [COMP_W-1:0]  s1_comp_reg;
    logic               s1_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_we_reg  <= 1'b0;
            s1_fin_reg <= 1'b0;
        end
        else
        begin
            s1_we_reg  <= in_accept && s0_we;
            s1_fin_reg <= in_accept && s0_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cls_reg   <= rd_addr_a;
        s1_phred_reg <= phred_q16(quality);
        s1_comp_reg  <= comp_q16(quality);
        s1_zero_reg  <= (quality == '0);
    end

    // ---------------------------------------------------------------
    // Accumulator RAM: 2 entries, 1 write, 2 registered reads
    // ---------------------------------------------------------------
    entry_t acc_mem [0:1];
    entry_t rd_a_reg;
    entry_t rd_b_reg;
    entry_t wr_data;
    logic   mem_we;

    always_ff @(posedge clk)
    begin
        rd_a_reg <= acc_mem[rd_addr_a];
        rd_b_reg <= acc_mem[~rd_addr_a];
        if (mem_we)
        begin
            acc_mem[s1_cls_reg] <= wr_data;
        end
    end

    // Entry valid bits: cleared by reset and by finish, invalid reads as zero.
    // The last write is registered to cover the read issued on the same edge.
    logic [1:0] ent_valid_reg;
    logic [1:0] ent_valid_next;
    logic       wb_valid_reg;
    logic       wb_addr_reg;
    entry_t     wb_data_reg;
    logic       saturated_reg;
    logic       saturated_next;

    entry_t ent_a;
    entry_t ent_b;
    entry_t abn_e;
    entry_t norm_e;

    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s1_cls_reg))
            ent_a = wb_data_reg;
        else if (ent_valid_reg[s1_cls_reg])
            ent_a = rd_a_reg;
        else
            ent_a = '0;

        if (wb_valid_reg && (wb_addr_reg == ~s1_cls_reg))
            ent_b = wb_data_reg;
        else if (ent_valid_reg[~s1_cls_reg])
            ent_b = rd_b_reg;
        else
            ent_b = '0;
    end

    // on finish, port A holds the abnormal entry
    assign abn_e  = ent_a;
    assign norm_e = ent_b;

    // ---------------------------------------------------------------
    // Stage 1: read-modify-write, or gather sums on finish
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] cnt_inc;
    logic             cnt_hit;

    always_comb
    begin
        if (ent_a.cnt >= CMAX)
            cnt_inc = CMAX;
        else
            cnt_inc = ent_a.cnt + CNT_W'(1);
        cnt_hit = (cnt_inc == CMAX);

        wr_data.phred = sat_add(ent_a.phred, LLH_W'(s1_phred_reg));
        wr_data.comp  = sat_add(ent_a.comp, LLH_W'(s1_comp_reg));
        wr_data.zero  = ent_a.zero || s1_zero_reg;
        wr_data.cnt   = cnt_inc;
    end

    assign mem_we = s1_we_reg;

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        saturated_next = saturated_reg;
        if (s1_fin_reg)
        begin
            ent_valid_next = '0;
            saturated_next = 1'b0;
        end
        else if (s1_we_reg)
        begin
            ent_valid_next[s1_cls_reg] = 1'b1;
            saturated_next             = saturated_reg || cnt_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            saturated_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            saturated_reg <= saturated_next;
            wb_valid_reg  <= s1_we_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= s1_cls_reg;
        wb_data_reg <= wr_data;
    end

    logic              s2_fin_reg;
    logic [LLH_W:0]    s2_ref_sum_reg;
    logic [LLH_W:0]    s2_alt_sum_reg;
    logic [PROD_W-1:0] s2_het_prod_reg;
    logic              s2_norm_zero_reg;
    logic              s2_abn_zero_reg;
    logic [CNT_W-1:0]  s2_norm_cnt_reg;
    logic [CNT_W-1:0]  s2_abn_cnt_reg;
    logic              s2_sat_reg;
    logic [TOT_W-1:0]  tot;

    assign tot = {1'b0, abn_e.cnt} + {1'b0, norm_e.cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_fin_reg <= 1'b0;
        else
            s2_fin_reg <= s1_fin_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_ref_sum_reg   <= {1'b0, abn_e.phred} + {1'b0, norm_e.comp};
        s2_alt_sum_reg   <= {1'b0, norm_e.phred} + {1'b0, abn_e.comp};
        s2_het_prod_reg  <= PROD_W'(tot) * PROD_W'(LOG_PLOIDY);
        s2_norm_zero_reg <= norm_e.zero;
        s2_abn_zero_reg  <= abn_e.zero;
        s2_norm_cnt_reg  <= norm_e.cnt;
        s2_abn_cnt_reg   <= abn_e.cnt;
        s2_sat_reg       <= saturated_reg;
    end

    // ---------------------------------------------------------------
    // Stage 2: clamp, negate, clip counts
    // ---------------------------------------------------------------
    logic [LLH_W-1:0] ref_mag;
    logic [LLH_W-1:0] alt_mag;
    logic [LLH_W-1:0] het_mag;
    logic [CX_W-1:0]  norm_cx;
    logic [CX_W-1:0]  abn_cx;
    logic             norm_clip;
    logic             abn_clip;
    result_t          res;

    always_comb
    begin
        if (s2_norm_zero_reg || (s2_ref_sum_reg > SUM_MAX_X))
            ref_mag = SUM_MAX;
        else
            ref_mag = s2_ref_sum_reg[LLH_W-1:0];

        if (s2_abn_zero_reg || (s2_alt_sum_reg > SUM_MAX_X))
            alt_mag = SUM_MAX;
        else
            alt_mag = s2_alt_sum_reg[LLH_W-1:0];

        if ((LLH_W+1)'(s2_het_prod_reg) > SUM_MAX_X)
            het_mag = SUM_MAX;
        else
            het_mag = LLH_W'(s2_het_prod_reg);

        norm_cx   = CX_W'(s2_norm_cnt_reg);
        abn_cx    = CX_W'(s2_abn_cnt_reg);
        norm_clip = norm_cx > CX_W'(16'hFFFF);
        abn_clip  = abn_cx > CX_W'(16'hFFFF);

        res.ref_llh  = LLH_W'(0) - ref_mag;
        res.ref_inf  = s2_norm_zero_reg;
        res.het      = LLH_W'(0) - het_mag;
        res.alt_llh  = LLH_W'(0) - alt_mag;
        res.alt_inf  = s2_abn_zero_reg;
        res.norm_cnt = norm_clip ? 16'hFFFF : norm_cx[15:0];
        res.abn_cnt  = abn_clip ? 16'hFFFF : abn_cx[15:0];
        res.ovf      = s2_sat_reg || norm_clip || abn_clip;
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    result_t          oq_mem [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0] oq_wr_ptr_reg;
    logic [OQ_AW-1:0] oq_rd_ptr_reg;
    logic [OQ_AW:0]   oq_occ_reg;
    logic [OQ_AW:0]   oq_occ_next;
    logic             oq_pop;
    logic [OQ_AW+1:0] oq_commit;
    result_t          head;

    assign oq_pop = out_valid && !out_stall;

    // queued results plus finish beats still in the pipe
    assign oq_commit = (OQ_AW+2)'(oq_occ_reg) + (OQ_AW+2)'(s1_fin_reg)
                     + (OQ_AW+2)'(s2_fin_reg);
    assign in_stall  = oq_commit >= (OQ_AW+2)'(OQ_DEPTH);

    always_comb
    begin
        oq_occ_next = oq_occ_reg;
        if (s2_fin_reg && !oq_pop)
            oq_occ_next = oq_occ_reg + (OQ_AW+1)'(1);
        else if (!s2_fin_reg && oq_pop)
            oq_occ_next = oq_occ_reg - (OQ_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_occ_reg    <= '0;
        end
        else
        begin
            oq_occ_reg <= oq_occ_next;
            if (s2_fin_reg)
                oq_wr_ptr_reg <= oq_wr_ptr_reg + OQ_AW'(1);
            if (oq_pop)
                oq_rd_ptr_reg <= oq_rd_ptr_reg + OQ_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fin_reg)
            oq_mem[oq_wr_ptr_reg] <= res;
    end

    assign head            = oq_mem[oq_rd_ptr_reg];
    assign out_valid       = (oq_occ_reg != '0);
    assign hom_ref_llh     = head.ref_llh;
    assign hom_ref_neg_inf = head.ref_inf;
    assign het_llh         = head.het;
    assign hom_alt_llh     = head.alt_llh;
    assign hom_alt_neg_inf = head.alt_inf;
    assign normal_count    = head.norm_cnt;
    assign abnormal_count  = head.abn_cnt;
    assign count_overflow  = head.ovf;

endmodule

FILE: tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgl_pkg::*;

    // magnitude ceiling of every Q16 sum, 2^37
    localparam longint unsigned MAG_CEIL = 64'd1 << 37;
    localparam int unsigned COUNT_CEIL = 65535;
    // round(65536 * log10(2)), diploid
    localparam longint unsigned LOG10_PLOIDY_Q16 = 19728;
    localparam int unsigned COMP_ENTRIES = 48;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [15:0] GOOD_FLAGS = FLAG_PAIRED | FLAG_PROPER_PAIR;
    localparam logic [15:0] BAD_FLAGS = FLAG_UNMAPPED | FLAG_MATE_UNMAP
                                      | FLAG_DUPLICATE | FLAG_SUPPLEMENT;
    localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;
    // a finish beat passes both stage registers before it shows; beats with no result may still be in flight
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 120;
    // bounds a run of ~700 beats with gaps, stalls and one long hold
    localparam longint CYCLE_LIMIT = 100_000;

    // -log10(1 - 10^(-q/10)) in Q16, rounded; no term from q = 48 up
    localparam int unsigned COMP_TERM [COMP_ENTRIES] = '{
        0, 45012, 28372, 19796, 14449, 10819, 8233, 6334,
        4911, 3830, 2999, 2356, 1855, 1463, 1156, 915,
        724, 574, 455, 361, 286, 227, 180, 143,
        114, 90, 72, 57, 45, 36, 28, 23,
        18, 14, 11, 9, 7, 6, 5, 4,
        3, 2, 2, 1, 1, 1, 1, 1
    };

    typedef struct {
        logic [1:0]  opcode;
        logic [7:0]  quality;
        logic [15:0] read_flags;
        logic [30:0] read_pos;
        logic [30:0] ref_length;
    } geno_beat_t;

    typedef struct {
        logic signed [37:0] hom_ref_llh;
        logic               hom_ref_neg_inf;
        logic signed [37:0] het_llh;
        logic signed [37:0] hom_alt_llh;
        logic               hom_alt_neg_inf;
        logic [15:0]        normal_count;
        logic [15:0]        abnormal_count;
        logic               count_overflow;
    } geno_llh_t;

    // Tracks per-genotype sums and queues the likelihoods each finish beat yields
    class llh_tracker;
        int unsigned errors;
        geno_llh_t pending_llh[$];
        longint unsigned ins_point;
        int unsigned min_qual;
        longint unsigned abn_phred, abn_comp, norm_phred, norm_comp;
        bit abn_zero, norm_zero, saturated;
        int unsigned abn_n, norm_n;

        function new();
            errors = 0;
            ins_point = 0;
            min_qual = 0;
            clear();
        endfunction

        function void clear();
            abn_phred = 0;
            abn_comp = 0;
            norm_phred = 0;
            norm_comp = 0;
            abn_zero = 0;
            norm_zero = 0;
            saturated = 0;
            abn_n = 0;
            norm_n = 0;
        endfunction

        function void set_reg(logic idx, longint unsigned value);
            if (idx == REG_INSERTION_POINT)
                ins_point = value & 64'h7FFF_FFFF;
            else
                min_qual = int'(value & 64'hFF);
        endfunction

        function longint unsigned sat_sum(longint unsigned a, longint unsigned b);
            return (a + b > MAG_CEIL) ? MAG_CEIL : a + b;
        endfunction

        function int unsigned bump(int unsigned c);
            if (c >= COUNT_CEIL) begin
                saturated = 1;
                return COUNT_CEIL;
            end
            if (c + 1 >= COUNT_CEIL)
                saturated = 1;
            return c + 1;
        endfunction

        function void add_score(bit normal, int unsigned q);
            longint unsigned phred;
            longint unsigned comp;
            phred = (longint'(q) * 65536 + 5) / 10;
            comp = (q < COMP_ENTRIES) ? COMP_TERM[q] : 0;
            if (normal) begin
                norm_phred = sat_sum(norm_phred, phred);
                if (q == 0)
                    norm_zero = 1;
                else
                    norm_comp = sat_sum(norm_comp, comp);
                norm_n = bump(norm_n);
            end
            else begin
                abn_phred = sat_sum(abn_phred, phred);
                if (q == 0)
                    abn_zero = 1;
                else
                    abn_comp = sat_sum(abn_comp, comp);
                abn_n = bump(abn_n);
            end
        endfunction

        function void absorb_beat(geno_beat_t b);
            longint unsigned span_lo, span_hi, hom_ref, hom_alt, het;
            bit flags_ok;
            geno_llh_t r;
            case (b.opcode)
                OP_ABNORMAL: add_score(0, b.quality);
                OP_CANDIDATE: begin
                    span_lo = longint'(b.read_pos) + 1;
                    span_hi = (b.ref_length == 0) ? span_lo
                                                  : span_lo + b.ref_length - 1;
                    flags_ok = ((b.read_flags & GOOD_FLAGS) == GOOD_FLAGS)
                            && ((b.read_flags & BAD_FLAGS) == 16'h0);
                    if (flags_ok && b.quality >= min_qual
                        && ins_point >= span_lo && ins_point <= span_hi)
                        add_score(1, b.quality);
                end
                OP_FINISH: begin
                    hom_ref = norm_zero ? MAG_CEIL : sat_sum(abn_phred, norm_comp);
                    hom_alt = abn_zero ? MAG_CEIL : sat_sum(norm_phred, abn_comp);
                    het = (longint'(abn_n) + norm_n) * LOG10_PLOIDY_Q16;
                    if (het > MAG_CEIL)
                        het = MAG_CEIL;
                    r.hom_ref_llh = 38'(0 - hom_ref);
                    r.hom_ref_neg_inf = norm_zero;
                    r.het_llh = 38'(0 - het);
                    r.hom_alt_llh = 38'(0 - hom_alt);
                    r.hom_alt_neg_inf = abn_zero;
                    r.normal_count = (norm_n > 16'hFFFF) ? 16'hFFFF : 16'(norm_n);
                    r.abnormal_count = (abn_n > 16'hFFFF) ? 16'hFFFF : 16'(abn_n);
                    r.count_overflow = saturated || norm_n > 16'hFFFF
                                    || abn_n > 16'hFFFF;
                    pending_llh.push_back(r);
                    clear();
                end
                default: ;
            endcase
        endfunction

        function void mismatch(string field, longint want, longint got);
            errors++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void compare_llh(geno_llh_t got);
            geno_llh_t want;
            if (pending_llh.size() == 0) begin
                errors++;
                $error("result beat with no finish beat outstanding");
                return;
            end
            want = pending_llh.pop_front();
            if (got.hom_ref_llh !== want.hom_ref_llh)
                mismatch("hom_ref_llh", want.hom_ref_llh, got.hom_ref_llh);
            if (got.hom_ref_neg_inf !== want.hom_ref_neg_inf)
                mismatch("hom_ref_neg_inf", want.hom_ref_neg_inf, got.hom_ref_neg_inf);
            if (got.het_llh !== want.het_llh)
                mismatch("het_llh", want.het_llh, got.het_llh);
            if (got.hom_alt_llh !== want.hom_alt_llh)
                mismatch("hom_alt_llh", want.hom_alt_llh, got.hom_alt_llh);
            if (got.hom_alt_neg_inf !== want.hom_alt_neg_inf)
                mismatch("hom_alt_neg_inf", want.hom_alt_neg_inf, got.hom_alt_neg_inf);
            if (got.normal_count !== want.normal_count)
                mismatch("normal_count", want.normal_count, got.normal_count);
            if (got.abnormal_count !== want.abnormal_count)
                mismatch("abnormal_count", want.abnormal_count, got.abnormal_count);
            if (got.count_overflow !== want.count_overflow)
                mismatch("count_overflow", want.count_overflow, got.count_overflow);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write_en = 1'b0;
    logic               cfg_index = REG_INSERTION_POINT;
    logic [30:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = OP_ABNORMAL;
    logic [7:0]         quality = '0;
    logic [15:0]        read_flags = '0;
    logic [30:0]        read_pos = '0;
    logic [30:0]        ref_length = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [37:0] hom_ref_llh;
    logic               hom_ref_neg_inf;
    logic signed [37:0] het_llh;
    logic signed [37:0] hom_alt_llh;
    logic               hom_alt_neg_inf;
    logic [15:0]        normal_count;
    logic [15:0]        abnormal_count;
    logic               count_overflow;

    llh_tracker board;

    // Sender state: current config as the stimulus sees it, burst bookkeeping
    longint      cur_ip = 0;
    int unsigned cur_mq = 0;
    bit          steady = 0;
    int unsigned burst_left = 0;
    // set by the sender, consumed by the receiver to start a long hold-off
    bit          hold_request = 0;
    longint      cycle_count = 0;

    read_genotype_likelihood i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .quality         (quality),
        .read_flags      (read_flags),
        .read_pos        (read_pos),
        .ref_length      (ref_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hom_ref_llh     (hom_ref_llh),
        .hom_ref_neg_inf (hom_ref_neg_inf),
        .het_llh         (het_llh),
        .hom_alt_llh     (hom_alt_llh),
        .hom_alt_neg_inf (hom_alt_neg_inf),
        .normal_count    (normal_count),
        .abnormal_count  (abnormal_count),
        .count_overflow  (count_overflow)
    );

    always #5 clk = ~clk;

    // Watchdog: a hang or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result monitor: sample pre-edge values, one beat per unstalled valid edge
    always @(posedge clk)
    begin
        geno_llh_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.hom_ref_llh = hom_ref_llh;
            got.hom_ref_neg_inf = hom_ref_neg_inf;
            got.het_llh = het_llh;
            got.hom_alt_llh = hom_alt_llh;
            got.hom_alt_neg_inf = hom_alt_neg_inf;
            got.normal_count = normal_count;
            got.abnormal_count = abnormal_count;
            got.count_overflow = count_overflow;
            board.compare_llh(got);
        end
    end

    // Receiver: stall pattern changes at random intervals; a hold request
    // freezes the output for a long stretch so the result buffer fills and
    // the block backs up into its input.
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(posedge clk);
            tick++;
            if (hold_request) begin
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Drive one beat, hold it until accepted, then maybe open a gap.
    // Returns on the accepting edge when no gap follows, so the next beat
    // goes out back to back with valid left high.
    task automatic send(geno_beat_t b);
        in_valid <= 1'b1;
        opcode <= b.opcode;
        quality <= b.quality;
        read_flags <= b.read_flags;
        read_pos <= b.read_pos;
        ref_length <= b.ref_length;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.absorb_beat(b);
        if (!steady) begin
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    // Both registers, written only with the block drained
    task automatic write_config(longint ip, int unsigned mq);
        in_valid <= 1'b0;
        while (board.pending_llh.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_INSERTION_POINT;
        cfg_data <= 31'(ip);
        @(posedge clk);
        board.set_reg(REG_INSERTION_POINT, ip);
        cfg_index <= REG_MIN_QUALITY;
        cfg_data <= 31'(mq);
        @(posedge clk);
        board.set_reg(REG_MIN_QUALITY, mq);
        cfg_write_en <= 1'b0;
        cur_ip = ip;
        cur_mq = mq;
    endtask

    function automatic geno_beat_t make_beat(logic [1:0] op, logic [7:0] q,
                                             logic [15:0] fl, logic [30:0] pos,
                                             logic [30:0] len);
        geno_beat_t b;
        b.opcode = op;
        b.quality = q;
        b.read_flags = fl;
        b.read_pos = pos;
        b.ref_length = len;
        return b;
    endfunction

    function automatic geno_beat_t junk_beat(logic [1:0] op);
        return make_beat(op, 8'($urandom), 16'($urandom), 31'($urandom),
                         31'($urandom));
    endfunction

    // Quality biased to the table range and to the threshold edges
    function automatic logic [7:0] pick_quality();
        case ($urandom_range(0, 6))
            0, 1: return 8'($urandom_range(0, 60));
            2: return 8'($urandom);
            3: return (cur_mq == 0) ? 8'd0 : 8'(cur_mq - 1);
            4: return 8'(cur_mq);
            5: return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
            default: return ($urandom_range(0, 1) != 0) ? 8'd47 : 8'd48;
        endcase
    endfunction

    // Mostly a properly paired read placed around the insertion point;
    // sometimes one flag goes bad or the span misses on either side.
    function automatic geno_beat_t candidate_beat();
        geno_beat_t b;
        longint span;
        longint pos;
        b = junk_beat(OP_CANDIDATE);
        b.quality = pick_quality();
        b.read_flags = GOOD_FLAGS | (16'($urandom) & ~BAD_FLAGS);
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
                0: b.read_flags &= ~FLAG_PAIRED;
                1: b.read_flags &= ~FLAG_PROPER_PAIR;
                2: b.read_flags |= FLAG_UNMAPPED;
                3: b.read_flags |= FLAG_MATE_UNMAP;
                4: b.read_flags |= FLAG_DUPLICATE;
                default: b.read_flags |= FLAG_SUPPLEMENT;
            endcase
        end
        span = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, POS_MAX))
                                           : longint'($urandom_range(0, 300));
        if ($urandom_range(0, 7) == 0)
            pos = cur_ip - 1 + longint'($urandom_range(0, 3));
        else
            pos = cur_ip - 1 - longint'($urandom_range(0, 32'(span) + 32'd2));
        if (pos < 0)
            pos = 0;
        if (pos > longint'(POS_MAX))
            pos = POS_MAX;
        b.read_pos = 31'(pos);
        b.ref_length = 31'(span);
        return b;
    endfunction

    // Genotypes of random length; a few are cut short by an early finish,
    // some carry raw noise reads or the unused opcode.
    task automatic random_phase(int unsigned n_items);
        int unsigned sent, len, k, r;
        geno_beat_t b;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(0, 12);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    b = junk_beat(OP_ABNORMAL);
                    b.quality = pick_quality();
                end
                else if (r < 88)
                    b = candidate_beat();
                else if (r < 94)
                    b = junk_beat(OP_CANDIDATE);
                else if (r < 97)
                    b = junk_beat(OP_UNUSED);
                else
                    b = junk_beat(OP_FINISH);
                send(b);
                if (b.opcode != OP_UNUSED)
                    sent++;
            end
            send(junk_beat(OP_FINISH));
            sent++;
            if ($urandom_range(0, 7) == 0)
                steady = !steady;
        end
        steady = 0;
    endtask

    // Abnormal beats and finishes, back to back, against a frozen receiver
    task automatic pressure_burst();
        geno_beat_t b;
        int k;
        steady = 1;
        hold_request = 1;
        for (k = 0; k < 24; k++) begin
            b = junk_beat(OP_ABNORMAL);
            b.quality = pick_quality();
            send(b);
            send(junk_beat(OP_FINISH));
        end
        steady = 0;
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: table edges, span edges, each flag rule, threshold edge
        write_config(1000, 20);
        send(make_beat(OP_ABNORMAL, 8'd0, 16'h0, 31'd0, 31'd0));
        send(make_beat(OP_ABNORMAL, 8'd1, 16'hFFFF, POS_MAX, POS_MAX));
        send(make_beat(OP_ABNORMAL, 8'd47, 16'h0, 31'd0, 31'd0));
        send(make_beat(OP_ABNORMAL, 8'd48, 16'h0, 31'd0, 31'd0));
        send(make_beat(OP_ABNORMAL, 8'd255, 16'h0, 31'd0, 31'd0));
        send(make_beat(OP_CANDIDATE, 8'd20, GOOD_FLAGS, 31'd999, 31'd1));
        send(make_beat(OP_CANDIDATE, 8'd19, GOOD_FLAGS, 31'd900, 31'd200));
        // zero length counts as a one-base span
        send(make_beat(OP_CANDIDATE, 8'd255, GOOD_FLAGS, 31'd999, 31'd0));
        send(make_beat(OP_CANDIDATE, 8'd30, GOOD_FLAGS, 31'd1000, 31'd50));
        send(make_beat(OP_CANDIDATE, 8'd30, GOOD_FLAGS, 31'd0, 31'd1000));
        send(make_beat(OP_CANDIDATE, 8'd30, GOOD_FLAGS, 31'd0, 31'd999));
        send(make_beat(OP_CANDIDATE, 8'd40, FLAG_PROPER_PAIR, 31'd0, 31'd2000));
        send(make_beat(OP_CANDIDATE, 8'd40, FLAG_PAIRED, 31'd0, 31'd2000));
        send(make_beat(OP_CANDIDATE, 8'd40, GOOD_FLAGS | FLAG_UNMAPPED, 31'd0, 31'd2000));
        send(make_beat(OP_CANDIDATE, 8'd40, GOOD_FLAGS | FLAG_MATE_UNMAP, 31'd0, 31'd2000));
        send(make_beat(OP_CANDIDATE, 8'd40, GOOD_FLAGS | FLAG_DUPLICATE, 31'd0, 31'd2000));
        send(make_beat(OP_CANDIDATE, 8'd40, GOOD_FLAGS | FLAG_SUPPLEMENT, 31'd0, 31'd2000));
        // unrelated flag bits do not matter
        send(make_beat(OP_CANDIDATE, 8'd40, 16'hF3F3, 31'd0, 31'd2000));
        send(make_beat(OP_CANDIDATE, 8'd255, GOOD_FLAGS, POS_MAX, POS_MAX));
        send(make_beat(OP_UNUSED, 8'd0, 16'hFFFF, POS_MAX, POS_MAX));
        send(make_beat(OP_FINISH, 8'd0, 16'h0, 31'd0, 31'd0));
        // empty genotype
        send(make_beat(OP_FINISH, 8'd255, 16'hFFFF, POS_MAX, POS_MAX));

        // zero-quality normal read: hom-ref goes to minus infinity
        write_config(50, 0);
        send(make_beat(OP_CANDIDATE, 8'd0, GOOD_FLAGS, 31'd49, 31'd1));
        send(make_beat(OP_ABNORMAL, 8'd10, 16'h0, 31'd0, 31'd0));
        send(make_beat(OP_FINISH, 8'd0, 16'h0, 31'd0, 31'd0));

        // Random phases over a spread of settings, extremes included
        write_config(1, 0);
        random_phase(130);

        write_config(POS_MAX, 255);
        random_phase(130);

        write_config($urandom_range(1, 100000), $urandom_range(0, 40));
        pressure_burst();
        random_phase(130);

        write_config(0, 0);
        random_phase(80);

        write_config($urandom_range(1, POS_MAX), 0);
        random_phase(130);

        // Drain: wait until everything expected has arrived, then let the block go quiet
        in_valid <= 1'b0;
        while (board.pending_llh.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending_llh.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
